// ===== hdl/wbps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard byte pattern search package
// Item types, configuration register indexes and fixed widths.
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int PATTERN_BYTES = 16;
    localparam int LENGTH_W      = 5;
    localparam int OUT_OFFSET_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 2'd3;

    localparam logic [LENGTH_W-1:0] LENGTH_RESET = 5'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic                    found;
        logic [OUT_OFFSET_W-1:0] match_offset;
    } out_item_t;

    typedef struct packed {
        logic [8*PATTERN_BYTES-1:0] pattern;
        logic [PATTERN_BYTES-1:0]   care;
        logic [LENGTH_W-1:0]        length;
    } wbps_cfg_t;

endpackage : wbps_pkg
`default_nettype wire

// ===== hdl/wbps_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// Pattern bytes, care mask and pattern length, written by index.
// ----------------------------------------------------------------------------
module wbps_cfg_regs
    import wbps_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output wbps_cfg_t                   cfg
);

    logic [63:0]               pattern_low_reg;
    logic [63:0]               pattern_high_reg;
    logic [PATTERN_BYTES-1:0]  care_reg;
    logic [LENGTH_W-1:0]       length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            care_reg         <= '0;
            length_reg       <= LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_reg  <= cfg_data[63:0];
                REG_PATTERN_HIGH: pattern_high_reg <= cfg_data[63:0];
                REG_CARE_MASK:    care_reg         <= cfg_data[PATTERN_BYTES-1:0];
                REG_PATTERN_LEN:  length_reg       <= cfg_data[LENGTH_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.pattern = {pattern_high_reg, pattern_low_reg};
    assign cfg.care    = care_reg;
    assign cfg.length  = length_reg;

endmodule : wbps_cfg_regs
`default_nettype wire

// ===== hdl/wbps_scan_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scan core
// Byte window, saturating byte count and match flag; masked window compare.
// ----------------------------------------------------------------------------
module wbps_scan_core
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      advance,
    input  wire in_item_t  item,
    input  wire wbps_cfg_t cfg,
    output logic           result_valid,
    output out_item_t      result
);

    localparam int WIN_IW    = $clog2(MAX_PATTERN);
    localparam int WIN_DEPTH = 1 << WIN_IW;
    localparam int EFF_W     = $clog2(MAX_PATTERN + 1);
    localparam int EXT_W     = (OFFSET_BITS > OUT_OFFSET_W) ? OFFSET_BITS : OUT_OFFSET_W;
    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

    logic [7:0]             win_reg [WIN_DEPTH];
    logic [7:0]             win_next [WIN_DEPTH];
    logic [OFFSET_BITS-1:0] count_reg;
    logic [OFFSET_BITS-1:0] count_next;
    logic                   reported_reg;

    logic [EFF_W-1:0]       plen;
    logic [EFF_W-1:0]       eff;
    logic [OFFSET_BITS-1:0] eff_wide;
    logic [OFFSET_BITS-1:0] diff;
    logic [EXT_W-1:0]       diff_ext;
    logic                   match_ok;
    logic                   hit;

    // shifted window, newest byte at entry 0
    always_comb
    begin
        win_next[0] = item.data_byte;
        for (int j = 1; j < WIN_DEPTH; j++)
        begin
            win_next[j] = win_reg[j-1];
        end
    end

    assign count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    // effective length: one past the highest cared position in use
    always_comb
    begin
        if (cfg.length > LENGTH_W'(MAX_PATTERN))
            plen = EFF_W'(MAX_PATTERN);
        else
            plen = EFF_W'(cfg.length);
        eff = '0;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (EFF_W'(k) < plen && cfg.care[k])
                eff = EFF_W'(k + 1);
        end
    end

    always_comb
    begin
        logic [WIN_IW-1:0] idx;
        match_ok = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            idx = WIN_IW'(eff - EFF_W'(k) - EFF_W'(1));
            if (EFF_W'(k) < eff && cfg.care[k] && win_next[idx] != cfg.pattern[8*k +: 8])
                match_ok = 1'b0;
        end
    end

    assign eff_wide = OFFSET_BITS'(eff);
    assign hit      = !reported_reg && (eff != '0) && (count_next >= eff_wide) && match_ok;
    assign diff     = count_next - eff_wide;
    assign diff_ext = EXT_W'(diff);

    assign result_valid        = hit || (item.last_byte && !reported_reg);
    assign result.found        = hit;
    assign result.match_offset = hit ? diff_ext[OUT_OFFSET_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < WIN_DEPTH; j++)
            begin
                win_reg[j] <= '0;
            end
            count_reg    <= '0;
            reported_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (item.last_byte)
            begin
                // clear for the next buffer
                for (int j = 0; j < WIN_DEPTH; j++)
                begin
                    win_reg[j] <= '0;
                end
                count_reg    <= '0;
                reported_reg <= 1'b0;
            end
            else
            begin
                for (int j = 0; j < WIN_DEPTH; j++)
                begin
                    win_reg[j] <= win_next[j];
                end
                count_reg    <= count_next;
                reported_reg <= reported_reg | hit;
            end
        end
    end

endmodule : wbps_scan_core
`default_nettype wire

// ===== hdl/wildcard_byte_pattern_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Timing: a byte accepted into the input register is compared combinationally by
//   the scan core, and its result is registered once the result slot can take it.
// Throughput: one byte per cycle unless out_ready stalls a full result slot.
// Reset: rst_n clears the window, byte count, match flag, stage valids and
//   the configuration (pattern length 1, everything else zero).
// ----------------------------------------------------------------------------
// Wildcard byte pattern search
// Input register, scan core and result register around a masked window compare.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_item_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_item_t                   out_data
);

    wbps_cfg_t  cfg;
    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    logic       fire;
    logic       core_valid;
    out_item_t  core_result;

    wbps_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wbps_scan_core #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (fire),
        .item         (in_item_reg),
        .cfg          (cfg),
        .result_valid (core_valid),
        .result       (core_result)
    );

    // advance when the result slot is free or being drained
    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= core_valid;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && core_valid)
            out_item_reg <= core_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule : wildcard_byte_pattern_search
`default_nettype wire

// ===== hdl/wbps_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker
// Result channel stability, not-found encoding and input availability.
// ----------------------------------------------------------------------------
module wbps_checker
    import wbps_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_ready,
    input  wire logic      out_valid,
    input  wire logic      out_ready,
    input  wire out_item_t out_data
);

    // hold a stalled result transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.match_offset == '0)
        else $error("not-found result with nonzero offset");

    // an empty result slot never blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && $past(out_valid && !out_ready) |-> out_valid || !out_ready)
        else $error("input accepted while result lost");

endmodule : wbps_checker

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte pattern search testbench
// Sends byte buffers over the input channel and compares every result
// transfer with a local scan predictor. Directed tests cover reset defaults,
// full-span and trailing-wildcard patterns, lengths out of range, short
// buffers and a register change mid-buffer. A random phase then runs many
// configurations, mostly with planted patterns, some near misses and noise.
// Both channels idle at random, with one stretch where neither side idles.
// ----------------------------------------------------------------------------
module tb_top;
    import wbps_pkg::*;

    localparam int RAND_ITEMS   = 1950;
    localparam int DRAIN_CYCLES = 6;
    localparam int WINDOW       = PATTERN_BYTES;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_PATTERN_LOW;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_data;

    wildcard_byte_pattern_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [15:0] care;
    logic [4:0]  plen;
    logic [7:0]  win [WINDOW];
    logic [31:0] seen;
    logic        reported;

    out_item_t   expected_q [$];
    logic [7:0]  buf_q [$];
    int          errors = 0;
    int          n_sent = 0;
    logic        calm   = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [7:0] pat_byte(input int k);
        if (k < 8)
            return pat_lo[8*k +: 8];
        return pat_hi[8*(k-8) +: 8];
    endfunction

    function automatic void clear_scan();
        for (int k = 0; k < WINDOW; k++)
            win[k] = 8'h00;
        seen     = '0;
        reported = 1'b0;
    endfunction

    function automatic int eff_len();
        int lim;
        int e;
        lim = (plen > WINDOW) ? WINDOW : int'(plen);
        e   = 0;
        for (int k = 0; k < lim; k++)
            if (care[k])
                e = k + 1;
        return e;
    endfunction

    function automatic logic window_hit(input int eff);
        for (int k = 0; k < eff; k++)
            if (care[k] && win[eff-1-k] != pat_byte(k))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void predict_search(input logic [7:0] b, input logic last);
        int        eff;
        out_item_t r;
        for (int k = WINDOW - 1; k > 0; k--)
            win[k] = win[k-1];
        win[0] = b;
        if (seen != 32'hFFFF_FFFF)
            seen = seen + 32'd1;
        eff = eff_len();
        if (!reported && eff != 0 && seen >= 32'(eff) && window_hit(eff))
        begin
            r              = '0;
            r.found        = 1'b1;
            r.match_offset = seen - 32'(eff);
            expected_q     = {expected_q, r};
            reported       = 1'b1;
        end
        if (last)
        begin
            if (!reported)
            begin
                r          = '0;
                expected_q = {expected_q, r};
            end
            clear_scan();
        end
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        buf_q = {buf_q, b};
    endfunction

    function automatic int idle_len();
        int n;
        n = 0;
        if (calm)
            return 0;
        while ($urandom_range(99) < 13)
            n++;
        return n;
    endfunction

    // result check and output-side stall
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual found=%0b offset=%0d",
                         $time, out_data.found, out_data.match_offset);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_data.found !== want.found)
                begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, out_data.found);
                    errors++;
                end
                if (out_data.match_offset !== want.match_offset)
                begin
                    $display("%0t: match_offset expected %0d actual %0d",
                             $time, want.match_offset, out_data.match_offset);
                    errors++;
                end
            end
        end
        out_ready <= calm || ($urandom_range(99) >= 13);
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {b, last};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_search(b, last);
        n_sent++;
    endtask

    task automatic scan_buffer();
        int n;
        n = buf_q.size();
        for (int i = 0; i < n; i++)
            send_byte(buf_q[i], i == n - 1);
        buf_q.delete();
    endtask

    // drop valid, wait for every result, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [15:0] cm, input logic [4:0] len);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        cfg_write <= 1'b1;
        cfg_index <= REG_PATTERN_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_PATTERN_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= REG_CARE_MASK;
        cfg_data  <= {junk[63:16], cm};
        @(posedge clk);
        cfg_index <= REG_PATTERN_LEN;
        cfg_data  <= {junk[63:5], len};
        @(posedge clk);
        cfg_write <= 1'b0;
        pat_lo = lo;
        pat_hi = hi;
        care   = cm;
        plen   = len;
    endtask

    task automatic test_reset_defaults();
        add_byte(8'h5A);
        scan_buffer();
    endtask

    task automatic test_full_span();
        settle();
        write_cfg(64'h0123_4567_89AB_CDFF, 64'h00FE_DCBA_9876_5432, 16'h8001, 5'd31);
        for (int i = 0; i < 15; i++)
            add_byte(8'hFF);
        add_byte(8'h00);
        scan_buffer();
    endtask

    task automatic test_never_match();
        settle();
        write_cfg(64'h0, 64'h0, 16'hFFFF, 5'd0);
        add_byte(8'h00);
        scan_buffer();
        settle();
        write_cfg(64'h0, 64'h0, 16'h0000, 5'd16);
        add_byte(8'h00);
        scan_buffer();
    endtask

    task automatic test_short_buffer();
        settle();
        write_cfg(64'h0, 64'h0, 16'h0007, 5'd3);
        add_byte(8'h00);
        add_byte(8'h00);
        scan_buffer();
    endtask

    task automatic test_trailing_wildcards();
        settle();
        write_cfg(64'h0000_0000_0000_CDAB, 64'h0, 16'h0003, 5'd8);
        add_byte(8'hAB);
        add_byte(8'hCD);
        scan_buffer();
    endtask

    task automatic test_mid_buffer_change();
        settle();
        write_cfg(64'h0000_0000_4433_2211, 64'h0, 16'h000F, 5'd4);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        settle();
        write_cfg(64'h0000_0000_0055_3322, 64'h0, 16'h0007, 5'd3);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic random_cfg();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [15:0] cm;
        logic [4:0]  len;
        int          sel;
        lo  = {$urandom, $urandom};
        hi  = {$urandom, $urandom};
        sel = $urandom_range(99);
        if (sel < 5)
        begin
            lo = '0;
            hi = '0;
        end
        else if (sel < 10)
        begin
            lo = '1;
            hi = '1;
        end
        cm  = 16'($urandom);
        sel = $urandom_range(99);
        if (sel < 8)
            cm = 16'h0000;
        else if (sel < 16)
            cm = 16'hFFFF;
        sel = $urandom_range(99);
        if (sel < 5)
            len = 5'd0;
        else if (sel < 12)
            len = 5'd16;
        else if (sel < 18)
            len = 5'($urandom_range(17, 31));
        else
            len = 5'($urandom_range(1, 8));
        write_cfg(lo, hi, cm, len);
    endtask

    task automatic test_random_scan();
        int   stop_at;
        int   bufs_left;
        int   eff;
        int   blen;
        int   start;
        logic plant;
        logic narrow;
        stop_at   = n_sent + RAND_ITEMS;
        bufs_left = 0;
        while (n_sent < stop_at)
        begin
            if (bufs_left == 0)
            begin
                settle();
                random_cfg();
                bufs_left = $urandom_range(1, 6);
            end
            calm   = (n_sent >= 800 && n_sent < 1100);
            eff    = eff_len();
            plant  = (eff != 0) && ($urandom_range(99) < 70);
            narrow = ($urandom_range(99) < 30);
            if (plant)
                blen = eff + $urandom_range(0, 20);
            else if ($urandom_range(99) < 85)
                blen = $urandom_range(1, 24);
            else
                blen = $urandom_range(25, 48);
            for (int i = 0; i < blen; i++)
                add_byte(narrow ? pat_byte($urandom_range(0, 15)) : 8'($urandom));
            if (plant)
            begin
                start = $urandom_range(0, blen - eff);
                for (int k = 0; k < eff; k++)
                    if (care[k])
                        buf_q[start+k] = pat_byte(k);
                // near miss: flip one bit of the last cared byte
                if ($urandom_range(99) < 15)
                    buf_q[start+eff-1] = buf_q[start+eff-1] ^ 8'(1 << $urandom_range(0, 7));
            end
            scan_buffer();
            bufs_left--;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        pat_lo = '0;
        pat_hi = '0;
        care   = '0;
        plen   = LENGTH_RESET;
        clear_scan();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_full_span();
        test_never_match();
        test_short_buffer();
        test_trailing_wildcards();
        test_mid_buffer_change();
        test_random_scan();
        settle();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
